// ----- design/ddo_pkg.sv -----
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the differential drive odometry
// state encoding, register map, cordic constants and arctangent table
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

   localparam int CORDIC_STEPS_DEF = 24;

   localparam logic [31:0] MPT_RESET    = 32'd464569;
   localparam logic [23:0] INVSEP_RESET = 24'd312076;

   // binary angle per radian, q32
   localparam logic [29:0] BAM_PER_RAD  = 30'd683565276;
   // cordic gain in q2.30
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [19:0] US_PER_S     = 20'd1000000;

   typedef enum logic {
      REG_MPT    = 1'b0,
      REG_INVSEP = 1'b1
   } reg_index_type;

   typedef enum logic [4:0] {
      S_IDLE, S_ML, S_MR, S_MD, S_DIFF, S_K1, S_K2, S_K3, S_K4,
      S_COR, S_PX, S_PY, S_VL, S_VR1, S_VR2, S_VR3, S_DIV, S_OUT
   } state_type;

   function automatic logic [31:0] atan_bam(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- design/diff_drive_odometry.sv -----
// an item with a new timestamp passes the multiply, cordic, position and divide states
//   to its result word; the next item is taken only when that word is registered,
//   which waits while an earlier result is still stalled at the output; the restoring
//   divider, run twice, sets most of the time per item
// a first sample or a repeated timestamp is absorbed without giving a result
// reset (synchronous, active high) clears pose and stored sample, registers to defaults
// ----------------------------------------------------------------------------
// diff_drive_odometry: dead-reckoning odometry for a differential drive
// one shared 33x33 multiplier, a cordic rotator and a serial divider run
// under a small sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_odometry
   import ddo_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  wire               clock,
   input  wire               reset,
   // sample channel
   input  wire               req_valid,
   output logic              req_ready,
   input  wire        [31:0] req_timestamp_us,
   input  wire signed [31:0] req_left_count,
   input  wire signed [31:0] req_right_count,
   // result channel
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic signed [31:0] rsp_pos_x,
   output logic signed [31:0] rsp_pos_y,
   output logic signed [31:0] rsp_heading,
   output logic signed [31:0] rsp_linear_speed,
   output logic signed [31:0] rsp_turn_rate,
   output logic signed [31:0] rsp_left_delta,
   output logic signed [31:0] rsp_right_delta,
   // register port
   input  wire               psel,
   input  wire               penable,
   input  wire               pwrite,
   input  wire        [2:0]  paddr,
   input  wire        [31:0] pwdata,
   output logic       [31:0] prdata,
   output logic              pready
);

   localparam int IW = $clog2(CORDIC_STEPS);

   // control state
   state_type   state_ff, state_in;
   logic        have_prev_ff, have_prev_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] mpt_ff, mpt_in;
   logic [23:0] invsep_ff, invsep_in;
   logic [31:0] prev_left_ff, prev_left_in;
   logic [31:0] prev_right_ff, prev_right_in;
   logic [31:0] prev_time_ff, prev_time_in;
   logic [31:0] pose_x_ff, pose_x_in;
   logic [31:0] pose_y_ff, pose_y_in;
   logic [31:0] pose_hd_ff, pose_hd_in;

   // datapath
   logic [31:0] dlb_ff, dlb_in;
   logic [31:0] drb_ff, drb_in;
   logic [31:0] dt_ff, dt_in;
   logic [31:0] dl_ff, dl_in;
   logic [31:0] dr_ff, dr_in;
   logic signed [31:0] travel_ff, travel_in;
   logic        diff_neg_ff, diff_neg_in;
   logic        diff_top_ff, diff_top_in;
   logic [56:0] m_ff, m_in;
   logic [32:0] bhi_ff, bhi_in;
   logic [40:0] rate_mag_ff, rate_mag_in;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic        flip_ff, flip_in;
   logic [IW-1:0] cor_cnt_ff, cor_cnt_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [63:0] rlo_ff, rlo_in;
   logic [63:0] vr_dvd_ff, vr_dvd_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [31:0] rem_ff, rem_in;
   logic [5:0]  div_cnt_ff, div_cnt_in;
   logic        div_sel_ff, div_sel_in;
   logic [31:0] lin_ff, lin_in;
   logic [31:0] turn_ff, turn_in;
   logic [31:0] o_x_ff, o_x_in, o_y_ff, o_y_in, o_hd_ff, o_hd_in;
   logic [31:0] o_lin_ff, o_lin_in, o_turn_ff, o_turn_in;
   logic [31:0] o_dl_ff, o_dl_in, o_dr_ff, o_dr_in;

   // shared multiplier operands
   logic signed [32:0] mul_a, mul_b;

   logic req_accept, csr_write;

   // rounding of a distance product to q16.16 with saturation
   function automatic logic [31:0] wheel_dist(input logic neg, input logic [63:0] p);
      logic [63:0] s;
      logic [47:0] q;
      s = p + 64'd32768;
      q = s[63:16];
      if (neg) begin
         wheel_dist = (q > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'd0 - q[31:0];
      end else begin
         wheel_dist = (q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end
   endfunction

   // saturating speed from a quotient magnitude
   function automatic logic [31:0] speed_sat(input logic neg, input logic [63:0] q);
      if (neg) begin
         speed_sat = (q > 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - q[31:0];
      end else begin
         speed_sat = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end
   endfunction

   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;
   assign pready     = 1'b1;
   assign csr_write  = psel && penable && pwrite;

   // register read back
   always_comb begin
      unique case (reg_index_type'(paddr[2]))
         REG_MPT:    prdata = mpt_ff;
         REG_INVSEP: prdata = {8'd0, invsep_ff};
      endcase
   end

   // outputs
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = o_x_ff;
   assign rsp_pos_y        = o_y_ff;
   assign rsp_heading      = o_hd_ff;
   assign rsp_linear_speed = o_lin_ff;
   assign rsp_turn_rate    = o_turn_ff;
   assign rsp_left_delta   = o_dl_ff;
   assign rsp_right_delta  = o_dr_ff;

   // sequencer and datapath
   always_comb begin
      logic [31:0] dt_new, amag, sel_mag;
      logic signed [32:0] diff33, sum33;
      logic [32:0] dmag;
      logic [63:0] lo_sum;
      logic [32:0] bam33;
      logic [31:0] half, bam, ang, ang2;
      logic [56:0] rsum;
      logic [4:0]  sh;
      logic signed [33:0] xs, ys, at, cc;
      logic signed [65:0] rnd;
      logic [32:0] r2;
      logic        qbit;
      logic [63:0] dvd_next;

      state_in      = state_ff;
      have_prev_in  = have_prev_ff;
      rsp_valid_in  = rsp_valid_ff;
      mpt_in        = mpt_ff;
      invsep_in     = invsep_ff;
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      prev_time_in  = prev_time_ff;
      pose_x_in     = pose_x_ff;
      pose_y_in     = pose_y_ff;
      pose_hd_in    = pose_hd_ff;
      dlb_in        = dlb_ff;
      drb_in        = drb_ff;
      dt_in         = dt_ff;
      dl_in         = dl_ff;
      dr_in         = dr_ff;
      travel_in     = travel_ff;
      diff_neg_in   = diff_neg_ff;
      diff_top_in   = diff_top_ff;
      m_in          = m_ff;
      bhi_in        = bhi_ff;
      rate_mag_in   = rate_mag_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      flip_in       = flip_ff;
      cor_cnt_in    = cor_cnt_ff;
      rlo_in        = rlo_ff;
      vr_dvd_in     = vr_dvd_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      div_sel_in    = div_sel_ff;
      lin_in        = lin_ff;
      turn_in       = turn_ff;
      o_x_in        = o_x_ff;
      o_y_in        = o_y_ff;
      o_hd_in       = o_hd_ff;
      o_lin_in      = o_lin_ff;
      o_turn_in     = o_turn_ff;
      o_dl_in       = o_dl_ff;
      o_dr_in       = o_dr_ff;
      mul_a         = '0;
      mul_b         = '0;

      dt_new  = req_timestamp_us - prev_time_ff;
      amag    = 32'd0;
      sel_mag = 32'd0;
      diff33  = '0;
      sum33   = '0;
      dmag    = '0;
      lo_sum  = '0;
      bam33   = '0;
      half    = '0;
      bam     = '0;
      ang     = '0;
      ang2    = '0;
      rsum    = '0;
      sh      = 5'(cor_cnt_ff);
      xs      = x_ff >>> sh;
      ys      = y_ff >>> sh;
      at      = {2'b00, atan_bam(sh)};
      cc      = '0;
      rnd     = '0;
      r2      = {rem_ff, dvd_ff[63]};
      qbit    = (r2 >= {1'b0, dt_ff});
      dvd_next = {dvd_ff[62:0], qbit};

      // the result word leaves the output register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         unique case (reg_index_type'(paddr[2]))
            REG_MPT:    mpt_in    = pwdata;
            REG_INVSEP: invsep_in = pwdata[23:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (!have_prev_ff) begin
                  // first sample only loads the stored counts and time
                  have_prev_in  = 1'b1;
                  prev_left_in  = req_left_count;
                  prev_right_in = req_right_count;
                  prev_time_in  = req_timestamp_us;
               end else if (dt_new != 32'd0) begin
                  dlb_in        = req_left_count - prev_left_ff;
                  drb_in        = req_right_count - prev_right_ff;
                  dt_in         = dt_new;
                  prev_left_in  = req_left_count;
                  prev_right_in = req_right_count;
                  prev_time_in  = req_timestamp_us;
                  state_in      = S_ML;
               end
            end
         end
         S_ML: begin
            amag  = dlb_ff[31] ? 32'd0 - dlb_ff : dlb_ff;
            mul_a = {1'b0, amag};
            mul_b = {1'b0, mpt_ff};
            state_in = S_MR;
         end
         S_MR: begin
            amag  = drb_ff[31] ? 32'd0 - drb_ff : drb_ff;
            mul_a = {1'b0, amag};
            mul_b = {1'b0, mpt_ff};
            dl_in = wheel_dist(dlb_ff[31], prod_ff[63:0]);
            state_in = S_MD;
         end
         S_MD: begin
            dr_in = wheel_dist(drb_ff[31], prod_ff[63:0]);
            state_in = S_DIFF;
         end
         S_DIFF: begin
            // travel is the floor of the mean, rotation is right minus left
            sum33  = $signed({dl_ff[31], dl_ff}) + $signed({dr_ff[31], dr_ff});
            diff33 = $signed({dr_ff[31], dr_ff}) - $signed({dl_ff[31], dl_ff});
            dmag   = diff33[32] ? 33'd0 - diff33 : diff33;
            travel_in   = sum33[32:1];
            diff_neg_in = diff33[32];
            diff_top_in = dmag[32];
            mul_a = {1'b0, dmag[31:0]};
            mul_b = {9'd0, invsep_ff};
            state_in = S_K1;
         end
         S_K1: begin
            m_in = prod_ff[56:0] + (diff_top_ff ? {1'b0, invsep_ff, 32'd0} : 57'd0);
            state_in = S_K2;
         end
         S_K2: begin
            mul_a = {8'd0, m_ff[56:32]};
            mul_b = {3'd0, BAM_PER_RAD};
            state_in = S_K3;
         end
         S_K3: begin
            mul_a  = {1'b0, m_ff[31:0]};
            mul_b  = {3'd0, BAM_PER_RAD};
            bhi_in = prod_ff[32:0];
            state_in = S_K4;
         end
         S_K4: begin
            // binary angle of the rotation, then the midpoint heading
            lo_sum = prod_ff[63:0] + 64'h8000_0000;
            bam33  = bhi_ff + {1'b0, lo_sum[63:32]};
            half   = bam33[32:1];
            bam    = bam33[31:0];
            if (diff_neg_ff) begin
               half = 32'd0 - half;
               bam  = 32'd0 - bam;
            end
            pose_hd_in = pose_hd_ff + bam;
            rsum        = m_ff + 57'd32768;
            rate_mag_in = rsum[56:16];
            // fold into the right half plane, negate the results afterwards
            ang     = pose_hd_ff + half;
            flip_in = ang[31] ^ ang[30];
            ang2    = (ang[31] ^ ang[30]) ? ang + 32'h8000_0000 : ang;
            x_in    = CORDIC_GAIN;
            y_in    = '0;
            z_in    = {{2{ang2[31]}}, ang2};
            cor_cnt_in = '0;
            state_in = S_COR;
         end
         S_COR: begin
            if (!z_ff[33]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + at;
            end
            cor_cnt_in = cor_cnt_ff + 1'b1;
            if (cor_cnt_ff == IW'(CORDIC_STEPS - 1)) begin
               state_in = S_PX;
            end
         end
         S_PX: begin
            cc    = flip_ff ? -x_ff : x_ff;
            mul_a = {travel_ff[31], travel_ff};
            mul_b = cc[32:0];
            state_in = S_PY;
         end
         S_PY: begin
            cc    = flip_ff ? -y_ff : y_ff;
            mul_a = {travel_ff[31], travel_ff};
            mul_b = cc[32:0];
            rnd   = prod_ff + 66'sd536870912;
            pose_x_in = pose_x_ff + rnd[61:30];
            state_in = S_VL;
         end
         S_VL: begin
            rnd   = prod_ff + 66'sd536870912;
            pose_y_in = pose_y_ff + rnd[61:30];
            sel_mag = travel_ff[31] ? 32'd0 - travel_ff : travel_ff;
            mul_a = {1'b0, sel_mag};
            mul_b = {13'd0, US_PER_S};
            state_in = S_VR1;
         end
         S_VR1: begin
            dvd_in = prod_ff[63:0];
            mul_a  = {1'b0, rate_mag_ff[31:0]};
            mul_b  = {13'd0, US_PER_S};
            state_in = S_VR2;
         end
         S_VR2: begin
            rlo_in = prod_ff[63:0];
            mul_a  = {24'd0, rate_mag_ff[40:32]};
            mul_b  = {13'd0, US_PER_S};
            state_in = S_VR3;
         end
         S_VR3: begin
            vr_dvd_in  = rlo_ff + {prod_ff[31:0], 32'd0};
            rem_in     = '0;
            div_cnt_in = '0;
            div_sel_in = 1'b0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            // restoring division, one quotient bit a cycle
            rem_in     = qbit ? 32'(r2 - {1'b0, dt_ff}) : r2[31:0];
            dvd_in     = dvd_next;
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'd63) begin
               rem_in     = '0;
               div_cnt_in = '0;
               if (!div_sel_ff) begin
                  lin_in     = speed_sat(travel_ff[31], dvd_next);
                  dvd_in     = vr_dvd_ff;
                  div_sel_in = 1'b1;
               end else begin
                  turn_in  = speed_sat(diff_neg_ff, dvd_next);
                  state_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               o_x_in    = pose_x_ff;
               o_y_in    = pose_y_ff;
               o_hd_in   = pose_hd_ff;
               o_lin_in  = lin_ff;
               o_turn_in = turn_ff;
               o_dl_in   = dlb_ff;
               o_dr_in   = drb_ff;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      prod_in = mul_a * mul_b;
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         have_prev_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         mpt_ff        <= MPT_RESET;
         invsep_ff     <= INVSEP_RESET;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         prev_time_ff  <= '0;
         pose_x_ff     <= '0;
         pose_y_ff     <= '0;
         pose_hd_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         have_prev_ff  <= have_prev_in;
         rsp_valid_ff  <= rsp_valid_in;
         mpt_ff        <= mpt_in;
         invsep_ff     <= invsep_in;
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
         prev_time_ff  <= prev_time_in;
         pose_x_ff     <= pose_x_in;
         pose_y_ff     <= pose_y_in;
         pose_hd_ff    <= pose_hd_in;
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      dlb_ff      <= dlb_in;
      drb_ff      <= drb_in;
      dt_ff       <= dt_in;
      dl_ff       <= dl_in;
      dr_ff       <= dr_in;
      travel_ff   <= travel_in;
      diff_neg_ff <= diff_neg_in;
      diff_top_ff <= diff_top_in;
      m_ff        <= m_in;
      bhi_ff      <= bhi_in;
      rate_mag_ff <= rate_mag_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      flip_ff     <= flip_in;
      cor_cnt_ff  <= cor_cnt_in;
      prod_ff     <= prod_in;
      rlo_ff      <= rlo_in;
      vr_dvd_ff   <= vr_dvd_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      div_cnt_ff  <= div_cnt_in;
      div_sel_ff  <= div_sel_in;
      lin_ff      <= lin_in;
      turn_ff     <= turn_in;
      o_x_ff      <= o_x_in;
      o_y_ff      <= o_y_in;
      o_hd_ff     <= o_hd_in;
      o_lin_ff    <= o_lin_in;
      o_turn_ff   <= o_turn_in;
      o_dl_ff     <= o_dl_in;
      o_dr_ff     <= o_dr_in;
   end

endmodule

`default_nettype wire

// ----- design/ddo_checker.sv -----
// ----------------------------------------------------------------------------
// ddo_checker: port-level checks for the odometry block
// watches handshakes and the register port over time
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [31:0] rsp_pos_x,
   input wire        pready
);

   // a result word held while stalled keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pos_x))
      else $error("result word changed while stalled");

   // a result only shows up after a busy stretch
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result word without a busy cycle");

   // reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("register port stalled");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_pos_x (rsp_pos_x),
   .pready    (pready)
);

`default_nettype wire
